@@ src/rvm_pkg.sv @@
`default_nettype none
package rvm_pkg;

	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic [30:0] ONE_U31 = 31'd1073741824;
	localparam logic [62:0] LIMIT_RESET = 63'd72058;

	// pi/2 in Q.30 and its multiples for range reduction
	localparam logic [33:0] HALF_PI = 34'd1686629713;
	localparam logic [33:0] HALF_PI_X2 = HALF_PI << 1;
	localparam logic [33:0] HALF_PI_X4 = HALF_PI << 2;
	localparam logic [33:0] HALF_PI_X8 = HALF_PI << 3;
	localparam logic [33:0] QUARTER_PI = HALF_PI >> 1;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 31;
	localparam int SQRT_LAT = SQRT_STEPS + 2;
	localparam int AXIS_LAT = DIV_STEPS + 2;
	localparam int SC_CORE_LAT = 22;
	localparam int SC_LAT = AXIS_LAT;
	localparam int MAT_LAT = 5;
	localparam int TOTAL_LAT = SQRT_LAT + AXIS_LAT + MAT_LAT;

	// taylor series divisors, lane 0 sine, lane 1 cosine
	localparam int SER_STEPS = 3;
	localparam logic [63:0] RCP_NUM = 64'd2147483648;
	localparam logic [6:0] DIV0 [2] = '{7'd72, 7'd90};
	localparam logic [29:0] RCP0 [2] = '{30'(RCP_NUM / 64'd72), 30'(RCP_NUM / 64'd90)};
	localparam logic [6:0] SER_DIV [SER_STEPS][2] = '{
		'{7'd42, 7'd56}, '{7'd20, 7'd30}, '{7'd6, 7'd12}};
	localparam logic [29:0] SER_RCP [SER_STEPS][2] = '{
		'{30'(RCP_NUM / 64'd42), 30'(RCP_NUM / 64'd56)},
		'{30'(RCP_NUM / 64'd20), 30'(RCP_NUM / 64'd30)},
		'{30'(RCP_NUM / 64'd6), 30'(RCP_NUM / 64'd12)}};

	typedef struct packed {
		logic valid;
		logic ident;
	} rvm_ctl_t;

endpackage
`default_nettype wire

@@ src/rotation_vector_to_matrix.sv @@
// channel    signals                                   transaction
// ---------  ----------------------------------------  ------------------------------
// input      start, busy, vec_x, vec_y, vec_z         start high and busy low
// result     done, r00..r22, identity_used             one cycle on done, no backpressure
// config     cfg_valid, cfg_ready, cfg_data            cfg_valid and cfg_ready high
//
// one vector accepted every cycle, busy is always low
// result follows acceptance through squares and sum (2), square root one bit
// a stage (32), axis division one quotient bit a stage and the matrix products (5)
// sine and cosine run beside the axis division and are delayed to match it
// reset clears all valid bits and loads the default small angle limit
`default_nettype none
module rotation_vector_to_matrix
	import rvm_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire signed [31:0]  vec_x,
	input  wire signed [31:0]  vec_y,
	input  wire signed [31:0]  vec_z,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [62:0]         cfg_data,
	output logic               done,
	output logic signed [31:0] r00,
	output logic signed [31:0] r10,
	output logic signed [31:0] r20,
	output logic signed [31:0] r01,
	output logic signed [31:0] r11,
	output logic signed [31:0] r21,
	output logic signed [31:0] r02,
	output logic signed [31:0] r12,
	output logic signed [31:0] r22,
	output logic               identity_used
);

	logic [62:0]        limit_q;
	rvm_ctl_t           sq_ctl;
	rvm_ctl_t           ax_ctl;
	logic [31:0]        angle;
	logic signed [31:0] sq_vx, sq_vy, sq_vz;
	logic signed [31:0] ux, uy, uz;
	logic               sc_valid;
	logic signed [31:0] sin_q30, cos_q30;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	rvm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.vec_x    (vec_x),
		.vec_y    (vec_y),
		.vec_z    (vec_z),
		.limit    (limit_q),
		.ctl_out  (sq_ctl),
		.angle    (angle),
		.vx_out   (sq_vx),
		.vy_out   (sq_vy),
		.vz_out   (sq_vz)
	);

	rvm_axis u_axis (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (sq_ctl),
		.angle   (angle),
		.vx      (sq_vx),
		.vy      (sq_vy),
		.vz      (sq_vz),
		.ctl_out (ax_ctl),
		.ux      (ux),
		.uy      (uy),
		.uz      (uz)
	);

	rvm_sincos u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_ctl.valid),
		.angle     (angle),
		.out_valid (sc_valid),
		.sin_q30   (sin_q30),
		.cos_q30   (cos_q30)
	);

	rvm_matrix u_matrix (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_in        (ax_ctl),
		.ux            (ux),
		.uy            (uy),
		.uz            (uz),
		.sin_q30       (sin_q30),
		.cos_q30       (cos_q30),
		.done          (done),
		.r00           (r00),
		.r10           (r10),
		.r20           (r20),
		.r01           (r01),
		.r11           (r11),
		.r21           (r21),
		.r02           (r02),
		.r12           (r12),
		.r22           (r22),
		.identity_used (identity_used)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##TOTAL_LAT done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOTAL_LAT))
		else $error("result without an accepted transaction");

	a_branch_align: assert property (@(posedge clk) disable iff (!arst_n)
		sc_valid == ax_ctl.valid)
		else $error("sine and axis pipelines out of step");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(done && identity_used) |-> (r00 == ONE_Q30) && (r11 == ONE_Q30)
			&& (r22 == ONE_Q30) && (r01 == 32'sd0) && (r12 == 32'sd0))
		else $error("identity flag without identity matrix");

endmodule
`default_nettype wire

@@ src/rvm_sqrt.sv @@
`default_nettype none
module rvm_sqrt
	import rvm_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire signed [31:0]  vec_x,
	input  wire signed [31:0]  vec_y,
	input  wire signed [31:0]  vec_z,
	input  wire [62:0]         limit,
	output rvm_ctl_t           ctl_out,
	output logic [31:0]        angle,
	output logic signed [31:0] vx_out,
	output logic signed [31:0] vy_out,
	output logic signed [31:0] vz_out
);

	logic signed [31:0] vin [3];
	logic               valid_s1;
	logic [63:0]        sq_s1 [3];
	logic signed [31:0] vec_s1 [3];
	logic [63:0]        len2;

	rvm_ctl_t           ctl_s [SQRT_STEPS+1];
	logic [63:0]        rem_s [SQRT_STEPS+1];
	logic [63:0]        res_s [SQRT_STEPS+1];
	logic signed [31:0] vec_s [SQRT_STEPS+1][3];

	assign vin[0] = vec_x;
	assign vin[1] = vec_y;
	assign vin[2] = vec_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s[0] <= '0;
		end else begin
			valid_s1 <= in_valid;
			ctl_s[0].valid <= valid_s1;
			ctl_s[0].ident <= len2 < {1'b0, limit};
		end
	end

	assign len2 = sq_s1[0] + sq_s1[1] + sq_s1[2];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= 64'(vin[i] * vin[i]);
			vec_s1[i] <= vin[i];
			vec_s[0][i] <= vec_s1[i];
		end
		rem_s[0] <= len2;
		res_s[0] <= '0;
	end

	// one result bit per stage, bit walks down two places at a time
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		logic        take;

		assign trial = res_s[k] + BIT;
		assign take = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? rem_s[k] - trial : rem_s[k];
			res_s[k+1] <= take ? (res_s[k] >> 1) + BIT : res_s[k] >> 1;
			for (int i = 0; i < 3; i++) begin
				vec_s[k+1][i] <= vec_s[k][i];
			end
		end
	end

	assign ctl_out = ctl_s[SQRT_STEPS];
	assign angle = res_s[SQRT_STEPS][31:0];
	assign vx_out = vec_s[SQRT_STEPS][0];
	assign vy_out = vec_s[SQRT_STEPS][1];
	assign vz_out = vec_s[SQRT_STEPS][2];

endmodule
`default_nettype wire

@@ src/rvm_axis.sv @@
`default_nettype none
module rvm_axis
	import rvm_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  rvm_ctl_t           ctl_in,
	input  wire [31:0]         angle,
	input  wire signed [31:0]  vx,
	input  wire signed [31:0]  vy,
	input  wire signed [31:0]  vz,
	output rvm_ctl_t           ctl_out,
	output logic signed [31:0] ux,
	output logic signed [31:0] uy,
	output logic signed [31:0] uz
);

	logic signed [31:0] vin [3];

	rvm_ctl_t    ctl_s [DIV_STEPS+1];
	logic [32:0] rem_s [DIV_STEPS+1][3];
	logic [30:0] quo_s [DIV_STEPS+1][3];
	logic        neg_s [DIV_STEPS+1][3];
	logic [31:0] ang_s [DIV_STEPS+1];
	logic        azero_s [DIV_STEPS+1];

	rvm_ctl_t    ctl_so;
	logic [31:0] u_so [3];

	assign vin[0] = vx;
	assign vin[1] = vy;
	assign vin[2] = vz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
			ctl_so <= '0;
		end else begin
			ctl_s[0] <= ctl_in;
			ctl_so <= ctl_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s[0][i] <= vin[i][31];
			rem_s[0][i] <= vin[i][31] ? ~{1'b1, vin[i]} + 33'd1 : {1'b0, vin[i]};
			quo_s[0][i] <= '0;
		end
		ang_s[0] <= angle;
		azero_s[0] <= angle == 32'd0;
	end

	// restoring division, magnitude never exceeds the angle so the quotient is Q1.30, signed result Q2.30
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int QB = DIV_STEPS - 1 - j;
		logic        ge [3];
		logic [31:0] nrem [3];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i] = rem_s[j][i] >= {1'b0, ang_s[j]};
				nrem[i] = ge[i] ? 32'(rem_s[j][i] - {1'b0, ang_s[j]}) : rem_s[j][i][31:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[j+1][i] <= {nrem[i], 1'b0};
				quo_s[j+1][i] <= quo_s[j][i] | (31'(ge[i]) << QB);
				neg_s[j+1][i] <= neg_s[j][i];
			end
			ang_s[j+1] <= ang_s[j];
			azero_s[j+1] <= azero_s[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (azero_s[DIV_STEPS]) begin
				u_so[i] <= '0;
			end else if (neg_s[DIV_STEPS][i]) begin
				u_so[i] <= ~{1'b0, quo_s[DIV_STEPS][i]} + 32'd1;
			end else begin
				u_so[i] <= {1'b0, quo_s[DIV_STEPS][i]};
			end
		end
	end

	assign ctl_out = ctl_so;
	assign ux = $signed(u_so[0]);
	assign uy = $signed(u_so[1]);
	assign uz = $signed(u_so[2]);

endmodule
`default_nettype wire

@@ src/rvm_sincos.sv @@
`default_nettype none
module rvm_sincos
	import rvm_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire [31:0]         angle,
	output logic               out_valid,
	output logic signed [31:0] sin_q30,
	output logic signed [31:0] cos_q30
);

	function automatic logic [30:0] div_fix(input logic [30:0] m, input logic [60:0] prod,
		input logic [6:0] d);
		logic [30:0] q0;
		logic [37:0] rem;
		q0 = {1'b0, prod[60:31]};
		rem = {7'd0, m} - 38'(q0) * 38'(d);
		return (rem >= {31'd0, d}) ? q0 + 31'd1 : q0;
	endfunction

	logic [SC_LAT:1] vld_s;
	logic [33:0]     a30;
	logic [33:0]     t1;
	logic [33:0]     t2;
	logic [33:0]     t3;
	logic [33:0]     t4;
	logic            g1;
	logic            g0;
	logic [33:0]     rr_s1;
	logic [30:0]     rr_s2;
	logic            swap;

	logic [1:0]      quad_s [2:21];
	logic            swap_s [3:21];
	logic [29:0]     x_s [3:19];
	logic [30:0]     x2_s [5:19];
	logic [59:0]     xx_s4;
	logic [60:0]     f_s6 [2];

	logic [30:0]     t_st [SER_STEPS+1][2];
	logic [61:0]     p_st [SER_STEPS][2];
	logic [30:0]     m_st [SER_STEPS][2];
	logic [30:0]     m2_st [SER_STEPS][2];
	logic [60:0]     r_st [SER_STEPS][2];

	logic [61:0]     ps_s20;
	logic [61:0]     pc_s20;
	logic [30:0]     sr_s21;
	logic [30:0]     cr_s21;
	logic [31:0]     sa;
	logic [31:0]     ca;
	logic [31:0]     s_s [SC_CORE_LAT:SC_LAT];
	logic [31:0]     c_s [SC_CORE_LAT:SC_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[SC_LAT-1:1], in_valid};
		end
	end

	// range reduction: remainder modulo pi/2, two quotient bits a stage
	always_comb begin
		a30 = {angle, 2'b00};
		t1 = (a30 >= HALF_PI_X8) ? a30 - HALF_PI_X8 : a30;
		t2 = (t1 >= HALF_PI_X4) ? t1 - HALF_PI_X4 : t1;
		g1 = rr_s1 >= HALF_PI_X2;
		t3 = g1 ? rr_s1 - HALF_PI_X2 : rr_s1;
		g0 = t3 >= HALF_PI;
		t4 = g0 ? t3 - HALF_PI : t3;
		swap = {3'd0, rr_s2} > QUARTER_PI;
	end

	always_ff @(posedge clk) begin
		rr_s1 <= t2;
		rr_s2 <= t4[30:0];
		quad_s[2] <= {g1, g0};
		swap_s[3] <= swap;
		x_s[3] <= swap ? 30'(HALF_PI - {3'd0, rr_s2}) : rr_s2[29:0];
		xx_s4 <= x_s[3] * x_s[3];
		x2_s[5] <= 31'((xx_s4 + 60'd536870912) >> 30);
		for (int l = 0; l < 2; l++) begin
			f_s6[l] <= x2_s[5] * RCP0[l];
			t_st[0][l] <= ONE_U31 - div_fix(x2_s[6], f_s6[l], DIV0[l]);
		end
		for (int n = 3; n < 22; n++) begin
			quad_s[n] <= quad_s[n-1];
		end
		for (int n = 4; n < 22; n++) begin
			swap_s[n] <= swap_s[n-1];
		end
		for (int n = 4; n < 20; n++) begin
			x_s[n] <= x_s[n-1];
		end
		for (int n = 6; n < 20; n++) begin
			x2_s[n] <= x2_s[n-1];
		end
	end

	// horner steps: multiply, round, reciprocal multiply, correct and subtract
	for (genvar g = 0; g < SER_STEPS; g++) begin : g_ser
		localparam int B = 8 + 4 * g;
		always_ff @(posedge clk) begin
			for (int l = 0; l < 2; l++) begin
				p_st[g][l] <= x2_s[B-1] * t_st[g][l];
				m_st[g][l] <= 31'((p_st[g][l] + 62'd536870912) >> 30);
				r_st[g][l] <= m_st[g][l] * SER_RCP[g][l];
				m2_st[g][l] <= m_st[g][l];
				t_st[g+1][l] <= ONE_U31 - div_fix(m2_st[g][l], r_st[g][l], SER_DIV[g][l]);
			end
		end
	end

	always_comb begin
		logic [31:0] se;
		logic [31:0] ce;
		se = swap_s[21] ? {1'b0, cr_s21} : {1'b0, sr_s21};
		ce = swap_s[21] ? {1'b0, sr_s21} : {1'b0, cr_s21};
		case (quad_s[21])
			2'd0: begin
				sa = se;
				ca = ce;
			end
			2'd1: begin
				sa = ce;
				ca = ~se + 32'd1;
			end
			2'd2: begin
				sa = ~se + 32'd1;
				ca = ~ce + 32'd1;
			end
			default: begin
				sa = ~ce + 32'd1;
				ca = se;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ps_s20 <= x_s[19] * t_st[SER_STEPS][0];
		pc_s20 <= x2_s[19] * t_st[SER_STEPS][1];
		sr_s21 <= 31'((ps_s20 + 62'd536870912) >> 30);
		cr_s21 <= ONE_U31 - (31'((pc_s20 + 62'd536870912) >> 30) >> 1);
		s_s[SC_CORE_LAT] <= sa;
		c_s[SC_CORE_LAT] <= ca;
		for (int n = SC_CORE_LAT + 1; n <= SC_LAT; n++) begin
			s_s[n] <= s_s[n-1];
			c_s[n] <= c_s[n-1];
		end
	end

	assign out_valid = vld_s[SC_LAT];
	assign sin_q30 = $signed(s_s[SC_LAT]);
	assign cos_q30 = $signed(c_s[SC_LAT]);

endmodule
`default_nettype wire

@@ src/rvm_matrix.sv @@
`default_nettype none
module rvm_matrix
	import rvm_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  rvm_ctl_t           ctl_in,
	input  wire signed [31:0]  ux,
	input  wire signed [31:0]  uy,
	input  wire signed [31:0]  uz,
	input  wire signed [31:0]  sin_q30,
	input  wire signed [31:0]  cos_q30,
	output logic               done,
	output logic signed [31:0] r00,
	output logic signed [31:0] r10,
	output logic signed [31:0] r20,
	output logic signed [31:0] r01,
	output logic signed [31:0] r11,
	output logic signed [31:0] r21,
	output logic signed [31:0] r02,
	output logic signed [31:0] r12,
	output logic signed [31:0] r22,
	output logic               identity_used
);

	// Q2.30 product rounding, half away from zero
	function automatic logic signed [33:0] mulq(input logic signed [65:0] p);
		logic [65:0] mag;
		logic [33:0] r;
		mag = p[65] ? 66'(-p) : 66'(p);
		r = 34'((mag + 66'd536870912) >> 30);
		return p[65] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] sat(input logic signed [35:0] v);
		if (v > 36'(ONE_Q30)) begin
			return ONE_Q30;
		end else if (v < -36'(ONE_Q30)) begin
			return -ONE_Q30;
		end else begin
			return 32'(v);
		end
	endfunction

	logic signed [31:0] uin [3];
	rvm_ctl_t           ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	logic signed [63:0] su_s1 [3];
	logic signed [63:0] sq_s1 [3];
	logic signed [63:0] pc_s1 [3];
	logic signed [32:0] omc_s1;
	logic signed [33:0] su_s2 [3];
	logic signed [33:0] sq_s2 [3];
	logic signed [33:0] pc_s2 [3];
	logic signed [32:0] omc_s2;
	logic signed [33:0] su_s3 [3];
	logic signed [32:0] kd_s3 [3];
	logic signed [32:0] ko_s3 [3];
	logic signed [32:0] omc_s3;
	logic signed [33:0] su_s4 [3];
	logic signed [65:0] od_s4 [3];
	logic signed [65:0] oo_s4 [3];

	logic signed [35:0] rd [3];
	logic signed [35:0] ro [3];
	logic signed [35:0] sx [3];

	assign uin[0] = ux;
	assign uin[1] = uy;
	assign uin[2] = uz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			done <= 1'b0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			done <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			su_s1[i] <= 64'(sin_q30 * uin[i]);
			sq_s1[i] <= 64'(uin[i] * uin[i]);
		end
		pc_s1[0] <= 64'(uin[0] * uin[1]);
		pc_s1[1] <= 64'(uin[0] * uin[2]);
		pc_s1[2] <= 64'(uin[1] * uin[2]);
		omc_s1 <= 33'(ONE_Q30) - 33'(cos_q30);

		for (int i = 0; i < 3; i++) begin
			su_s2[i] <= mulq(66'(su_s1[i]));
			sq_s2[i] <= mulq(66'(sq_s1[i]));
			pc_s2[i] <= mulq(66'(pc_s1[i]));
		end
		omc_s2 <= omc_s1;

		// diagonal of K*K is minus the other two squares
		kd_s3[0] <= 33'(-(sq_s2[1] + sq_s2[2]));
		kd_s3[1] <= 33'(-(sq_s2[0] + sq_s2[2]));
		kd_s3[2] <= 33'(-(sq_s2[0] + sq_s2[1]));
		for (int i = 0; i < 3; i++) begin
			ko_s3[i] <= 33'(pc_s2[i]);
			su_s3[i] <= su_s2[i];
		end
		omc_s3 <= omc_s2;

		for (int i = 0; i < 3; i++) begin
			od_s4[i] <= omc_s3 * kd_s3[i];
			oo_s4[i] <= omc_s3 * ko_s3[i];
			su_s4[i] <= su_s3[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rd[i] = 36'(mulq(od_s4[i])) + 36'(ONE_Q30);
			ro[i] = 36'(mulq(oo_s4[i]));
			sx[i] = 36'(su_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s4.ident) begin
			r00 <= ONE_Q30;
			r11 <= ONE_Q30;
			r22 <= ONE_Q30;
			r10 <= '0;
			r20 <= '0;
			r01 <= '0;
			r21 <= '0;
			r02 <= '0;
			r12 <= '0;
		end else begin
			r00 <= sat(rd[0]);
			r11 <= sat(rd[1]);
			r22 <= sat(rd[2]);
			r10 <= sat(sx[2] + ro[0]);
			r01 <= sat(ro[0] - sx[2]);
			r20 <= sat(ro[1] - sx[1]);
			r02 <= sat(sx[1] + ro[1]);
			r21 <= sat(sx[0] + ro[2]);
			r12 <= sat(ro[2] - sx[0]);
		end
		identity_used <= ctl_s4.ident;
	end

	a_entry_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (r00 <= ONE_Q30) && (r00 >= -ONE_Q30) && (r10 <= ONE_Q30)
			&& (r10 >= -ONE_Q30) && (r21 <= ONE_Q30) && (r21 >= -ONE_Q30))
		else $error("matrix entry outside unit range");

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
	import rvm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 120;
	localparam logic [62:0] LIMIT_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic signed [31:0] ent [9];
		logic               ident;
	} rot_matrix_t;

	class rotation_scoreboard;
		rot_matrix_t pending_q [$];
		logic [62:0] angle_limit = LIMIT_RESET;
		int errors = 0;
		string names [9] = '{"r00", "r10", "r20", "r01", "r11", "r21", "r02", "r12", "r22"};

		function automatic longint qmul(longint a, longint b);
			longint p;
			p = a * b;
			if (p >= 0)
				return (p + 64'sd536870912) >>> 30;
			return -(((-p) + 64'sd536870912) >>> 30);
		endfunction

		function automatic logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] res, b;
			res = 0;
			b = 64'h4000_0000_0000_0000;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// taylor series on [0, pi/4], horner form with truncating divisions
		function automatic void taylor_sin_cos(longint x, output longint s, output longint c);
			longint x2, t;
			x2 = qmul(x, x);
			t = ONE_Q30 - x2 / 72;
			t = ONE_Q30 - qmul(x2, t) / 42;
			t = ONE_Q30 - qmul(x2, t) / 20;
			t = ONE_Q30 - qmul(x2, t) / 6;
			s = qmul(x, t);
			t = ONE_Q30 - x2 / 90;
			t = ONE_Q30 - qmul(x2, t) / 56;
			t = ONE_Q30 - qmul(x2, t) / 30;
			t = ONE_Q30 - qmul(x2, t) / 12;
			c = ONE_Q30 - qmul(x2, t) / 2;
		endfunction

		function automatic void note_vector(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
			rot_matrix_t m;
			longint v [3], u [3], k [9], k2 [9], sq [3];
			longint sr, cr, s, c, omc, e, one;
			logic [63:0] len2, ang, a30, rem, quad, mag;
			one = ONE_Q30;
			v[0] = x; v[1] = y; v[2] = z;
			len2 = 0;
			for (int i = 0; i < 3; i++)
				len2 += 64'(v[i] * v[i]);
			if (len2 < {1'b0, angle_limit}) begin
				for (int i = 0; i < 9; i++)
					m.ent[i] = (i % 4 == 0) ? ONE_Q30 : 32'sd0;
				m.ident = 1'b1;
				pending_q.push_back(m);
				return;
			end
			ang = int_sqrt(len2);
			for (int i = 0; i < 3; i++) begin
				u[i] = 0;
				if (ang != 0) begin
					mag = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
					u[i] = longint'((mag << 30) / ang);
					if (v[i] < 0)
						u[i] = -u[i];
				end
			end
			a30 = ang << 2;
			quad = (a30 / 64'(HALF_PI)) & 64'd3;
			rem = a30 % 64'(HALF_PI);
			if (rem > 64'(HALF_PI) / 2)
				taylor_sin_cos(longint'(HALF_PI) - longint'(rem), cr, sr);
			else
				taylor_sin_cos(longint'(rem), sr, cr);
			case (quad)
				0: begin s = sr; c = cr; end
				1: begin s = cr; c = -sr; end
				2: begin s = -sr; c = -cr; end
				default: begin s = -cr; c = sr; end
			endcase
			omc = one - c;
			// column-major cross-product matrix
			k[0] = 0;     k[3] = -u[2]; k[6] = u[1];
			k[1] = u[2];  k[4] = 0;     k[7] = -u[0];
			k[2] = -u[1]; k[5] = u[0];  k[8] = 0;
			for (int i = 0; i < 3; i++)
				sq[i] = qmul(u[i], u[i]);
			k2[0] = -(sq[1] + sq[2]);
			k2[4] = -(sq[0] + sq[2]);
			k2[8] = -(sq[0] + sq[1]);
			k2[1] = qmul(u[0], u[1]); k2[3] = k2[1];
			k2[2] = qmul(u[0], u[2]); k2[6] = k2[2];
			k2[5] = qmul(u[1], u[2]); k2[7] = k2[5];
			for (int i = 0; i < 9; i++) begin
				e = (i % 4 == 0) ? one : 0;
				e += qmul(s, k[i]) + qmul(omc, k2[i]);
				if (e > one) e = one;
				if (e < -one) e = -one;
				m.ent[i] = 32'(e);
			end
			m.ident = 1'b0;
			pending_q.push_back(m);
		endfunction

		function automatic void check_matrix(rot_matrix_t got);
			rot_matrix_t want;
			if (pending_q.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
				return;
			end
			want = pending_q.pop_front();
			for (int i = 0; i < 9; i++)
				if (got.ent[i] !== want.ent[i]) begin
					$error("%s expected %0d actual %0d", names[i], want.ent[i], got.ent[i]);
					errors++;
				end
			if (got.ident !== want.ident) begin
				$error("identity_used expected %0b actual %0b", want.ident, got.ident);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [62:0] cfg_data = '0;
	logic done;
	logic signed [31:0] r00, r10, r20, r01, r11, r21, r02, r12, r22;
	logic identity_used;

	rotation_scoreboard sb = new();
	int cycles = 0;
	int idle_pct = 0;

	rotation_vector_to_matrix uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .r00(r00), .r10(r10), .r20(r20), .r01(r01), .r11(r11),
		.r21(r21), .r02(r02), .r12(r12), .r22(r22), .identity_used(identity_used)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		rot_matrix_t got;
		if (arst_n && done) begin
			got.ent = '{r00, r10, r20, r01, r11, r21, r02, r12, r22};
			got.ident = identity_used;
			sb.check_matrix(got);
		end
	end

	// start stays high between back-to-back vectors, dropped only for idle gaps
	task automatic send_vector(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		do @(posedge clk); while (busy);
		sb.note_vector(x, y, z);
	endtask

	task automatic drain;
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [62:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.angle_limit = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_comp();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 4)
			return $urandom;
		if (kind == 4)
			return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		return $signed($urandom) >>> $urandom_range(1, 30);
	endfunction

	task automatic random_vectors(int n);
		for (int i = 0; i < n; i++)
			send_vector(rand_comp(), rand_comp(), rand_comp());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero limit first: zero vector gives identity without the flag
		idle_pct = 14;
		write_limit(63'd0);
		send_vector(0, 0, 0);
		send_vector(32'sh7FFF_FFFF, 0, 0);
		send_vector(32'sh8000_0000, 0, 0);
		send_vector(0, 32'sh7FFF_FFFF, 0);
		send_vector(0, 32'sh8000_0000, 0);
		send_vector(0, 0, 32'sh7FFF_FFFF);
		send_vector(0, 0, 32'sh8000_0000);
		send_vector(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_vector(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_vector(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_vector(32'sd421657428, 0, 0);
		send_vector(0, 32'sd843314857, 0);
		send_vector(0, 0, -32'sd1264972285);
		send_vector(32'sd210828714, 32'sd210828714, 0);
		send_vector(1, 0, 0);
		send_vector(0, -1, 1);
		drain();

		write_limit(LIMIT_RESET);
		send_vector(268, 0, 0);
		send_vector(269, 0, 0);
		send_vector(155, 155, 155);
		send_vector(-156, 155, -155);
		random_vectors(250);
		drain();

		idle_pct = 83;
		write_limit(LIMIT_MAX);
		random_vectors(100);
		drain();

		write_limit(63'd1 << 48);
		random_vectors(200);
		drain();

		idle_pct = 0;
		write_limit(63'({$urandom, $urandom} >> $urandom_range(1, 40)));
		random_vectors(200);
		drain();

		if (sb.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
